/* hdl/ir_code_translator_transmitter_macros.svh */
// ----------------------------------------------------------------------------
// ir code translator transmitter assertion macros
// shared concurrent assertion forms, clocked with reset disable
// ----------------------------------------------------------------------------
`ifndef IR_CODE_TRANSLATOR_TRANSMITTER_MACROS_SVH
`define IR_CODE_TRANSLATOR_TRANSMITTER_MACROS_SVH

// same-cycle implication
`define ICT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ICT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ict_pkg.sv */
// ----------------------------------------------------------------------------
// ict_pkg
// shared types and constants of the ir code translator transmitter
// ----------------------------------------------------------------------------
`default_nettype none

package ict_pkg;

    localparam int SLOT_COUNT_DEF = 10;
    localparam int FRAME_BITS     = 120;
    localparam int POS_W          = 7;
    localparam int WORD_W         = 64;
    localparam int CODE_W         = 32;
    localparam int TICK_W         = 16;
    localparam int SLOT_PORT_W    = 4;
    localparam int QDEPTH         = 2;

    localparam logic [TICK_W-1:0] PERIOD_RST   = 16'd421;
    localparam logic [TICK_W-1:0] ON_TICKS_RST = 16'd140;
    localparam logic [TICK_W-1:0] BIT_TICKS_RST = 16'd8960;

    // input op codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_KEY   = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;
    localparam logic [1:0] OP_CODE  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_PERIOD    = 2'd0;
    localparam logic [1:0] REG_ON_TICKS  = 2'd1;
    localparam logic [1:0] REG_BIT_TICKS = 2'd2;

    typedef enum logic [2:0] {
        K_TICK,
        K_KEY,
        K_FRAME,
        K_CODE,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [SLOT_PORT_W-1:0]  slot;
        logic                    word_sel;
        logic [WORD_W-1:0]       word;
        logic [CODE_W-1:0]       code;
    } t_cmd;

    typedef struct packed {
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] on_ticks;
        logic [TICK_W-1:0] bit_ticks;
    } t_cfg;

endpackage

`default_nettype wire

/* hdl/ict_front.sv */
// ----------------------------------------------------------------------------
// ict_front
// accepts command beats and classifies them for the execution side
// ----------------------------------------------------------------------------
`default_nettype none

module ict_front #(
    parameter int SLOT_COUNT = ict_pkg::SLOT_COUNT_DEF
) (
    input  logic                                i_start,
    input  logic                                i_full,
    input  logic [1:0]                          i_op,
    input  logic [ict_pkg::SLOT_PORT_W-1:0]     i_slot,
    input  logic                                i_word_sel,
    input  logic [ict_pkg::WORD_W-1:0]          i_frame_word,
    input  logic signed [ict_pkg::CODE_W-1:0]   i_code,
    output logic                                o_busy,
    output logic                                o_push,
    output ict_pkg::t_cmd                       o_cmd
);
    import ict_pkg::*;

    logic slot_ok;

    assign slot_ok = {1'b0, i_slot} < (SLOT_PORT_W + 1)'(SLOT_COUNT);
    assign o_busy  = i_full;
    assign o_push  = i_start && !i_full;

    always_comb begin
        o_cmd.slot     = i_slot;
        o_cmd.word_sel = i_word_sel;
        o_cmd.word     = i_frame_word;
        o_cmd.code     = $unsigned(i_code);
        unique case (i_op)
            OP_TICK:  o_cmd.kind = K_TICK;
            // stores to a slot that does not exist do nothing
            OP_KEY:   o_cmd.kind = slot_ok ? K_KEY : K_NOP;
            OP_FRAME: o_cmd.kind = slot_ok ? K_FRAME : K_NOP;
            OP_CODE:  o_cmd.kind = K_CODE;
            default:  o_cmd.kind = K_NOP;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/ict_queue.sv */
// ----------------------------------------------------------------------------
// ict_queue
// short command queue between the front and the execution side
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_code_translator_transmitter_macros.svh"

module ict_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ict_pkg::t_cmd  i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output ict_pkg::t_cmd  o_cmd
);
    import ict_pkg::*;

    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_cmd               r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               pop;

    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    // the execution side takes one beat every cycle
    assign pop     = o_valid;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `ICT_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || pop, "queue push while full")
    `ICT_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QDEPTH), "queue count out of range")
    `ICT_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, i_push, o_valid, "pushed beat not visible")

endmodule

`default_nettype wire

/* hdl/ict_back.sv */
// ----------------------------------------------------------------------------
// ict_back
// executes commands: slot storage, code matching and frame transmission
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_code_translator_transmitter_macros.svh"

module ict_back #(
    parameter int SLOT_COUNT = ict_pkg::SLOT_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  ict_pkg::t_cmd                     i_cmd,
    input  ict_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    output logic                              o_led,
    output logic                              o_busy_res,
    output logic                              o_hit,
    output logic [ict_pkg::SLOT_PORT_W-1:0]   o_hit_slot
);
    import ict_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // slot storage
    logic [CODE_W-1:0]     r_keys   [SLOT_COUNT];
    logic [WORD_W-1:0]     r_frames [SLOT_COUNT][2];
    logic [SLOT_COUNT-1:0] r_key_valid;

    // transmit state
    logic                  r_sending;
    logic [SLOT_W-1:0]     r_slot;
    logic [POS_W-1:0]      r_pos;
    logic [TICK_W-1:0]     r_timer;
    logic [TICK_W-1:0]     r_phase;

    logic                  n_sending;
    logic [SLOT_W-1:0]     n_slot;
    logic [POS_W-1:0]      n_pos;
    logic [TICK_W-1:0]     n_timer;
    logic [TICK_W-1:0]     n_phase;

    // result
    logic                  r_valid;
    logic                  r_hit;
    logic [SLOT_W-1:0]     r_hit_slot;
    logic                  n_hit;

    logic [SLOT_COUNT-1:0] match;
    logic                  found;
    logic [SLOT_W-1:0]     found_idx;
    logic [TICK_W:0]       phase_inc;
    logic [TICK_W:0]       timer_inc;
    logic [POS_W:0]        pos_inc;
    logic [SLOT_W-1:0]     wr_slot;
    logic                  frame_bit;

    assign wr_slot = i_cmd.slot[SLOT_W-1:0];

    // lowest matching valid slot wins
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            match[s] = r_key_valid[s] && (r_keys[s] == i_cmd.code);
        end
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (match[s]) begin
                found     = 1'b1;
                found_idx = SLOT_W'(s);
            end
        end
    end

    assign phase_inc = {1'b0, r_phase} + 1'b1;
    assign timer_inc = {1'b0, r_timer} + 1'b1;
    assign pos_inc   = {1'b0, r_pos} + 1'b1;

    always_comb begin
        n_sending = r_sending;
        n_slot    = r_slot;
        n_pos     = r_pos;
        n_timer   = r_timer;
        n_phase   = r_phase;
        n_hit     = 1'b0;
        if (i_valid) begin
            case (i_cmd.kind)
                K_TICK: begin
                    if (r_sending) begin
                        n_phase = (phase_inc >= {1'b0, i_cfg.period}) ? '0 : phase_inc[TICK_W-1:0];
                        if (timer_inc >= {1'b0, i_cfg.bit_ticks}) begin
                            n_timer = '0;
                            if (pos_inc >= (POS_W + 1)'(FRAME_BITS)) begin
                                // frame done
                                n_sending = 1'b0;
                                n_pos     = '0;
                                n_phase   = '0;
                            end else begin
                                n_pos = pos_inc[POS_W-1:0];
                            end
                        end else begin
                            n_timer = timer_inc[TICK_W-1:0];
                        end
                    end
                end
                K_CODE: begin
                    if (!r_sending && found) begin
                        n_sending = 1'b1;
                        n_slot    = found_idx;
                        n_pos     = '0;
                        n_timer   = '0;
                        n_phase   = '0;
                        n_hit     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_valid <= '0;
            r_sending   <= 1'b0;
            r_slot      <= '0;
            r_pos       <= '0;
            r_timer     <= '0;
            r_phase     <= '0;
            r_valid     <= 1'b0;
            r_hit       <= 1'b0;
            r_hit_slot  <= '0;
        end else begin
            r_sending  <= n_sending;
            r_slot     <= n_slot;
            r_pos      <= n_pos;
            r_timer    <= n_timer;
            r_phase    <= n_phase;
            r_valid    <= i_valid;
            r_hit      <= n_hit;
            r_hit_slot <= n_hit ? n_slot : '0;
            if (i_valid && i_cmd.kind == K_KEY) begin
                r_key_valid[wr_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_cmd.kind == K_KEY) begin
            r_keys[wr_slot] <= i_cmd.code;
        end
        if (i_valid && i_cmd.kind == K_FRAME) begin
            r_frames[wr_slot][i_cmd.word_sel] <= i_cmd.word;
        end
    end

    // state registers hold the after-beat state during the result cycle
    assign frame_bit  = r_frames[r_slot][r_pos[POS_W-1]][r_pos[POS_W-2:0]];
    assign o_led      = r_sending && !frame_bit && (r_phase < i_cfg.on_ticks);
    assign o_valid    = r_valid;
    assign o_busy_res = r_sending;
    assign o_hit      = r_hit;
    assign o_hit_slot = SLOT_PORT_W'(r_hit_slot);

    `ICT_ASSERT_NOW(a_hit_sends, i_clk, i_rst_n, r_valid && r_hit, r_sending, "hit without sending")
    `ICT_ASSERT_NOW(a_idle_clear, i_clk, i_rst_n, !r_sending, (r_pos == '0) && (r_timer == '0) && (r_phase == '0), "counters not cleared while idle")
    `ICT_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, r_sending, r_pos < POS_W'(FRAME_BITS), "bit position past frame end")
    `ICT_ASSERT_NOW(a_miss_slot, i_clk, i_rst_n, !r_hit, r_hit_slot == '0, "slot reported without hit")

endmodule

`default_nettype wire

/* hdl/ir_code_translator_transmitter.sv */
// ----------------------------------------------------------------------------
// ir_code_translator_transmitter
// learning ir code translator with a carrier-modulated raw frame sender
// ----------------------------------------------------------------------------
//  channel    handshake                         payload
//  command    start / busy                      i_op i_slot i_word_sel i_frame_word i_code
//  result     o_valid strobe, one cycle         o_led o_busy_res o_hit o_hit_slot
//  registers  psel penable pwrite pready        paddr pwdata prdata
//
// one command beat per cycle while busy is low; its result strobes once the beat
// has passed the command queue stage and the result register
// busy rises only when the two-entry command queue is full
// synchronous active-low reset clears valid bits and transmit state, presets registers
// results cannot be held off by the receiver
// ----------------------------------------------------------------------------
`default_nettype none

module ir_code_translator_transmitter #(
    parameter int SLOT_COUNT = ict_pkg::SLOT_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_op,
    input  logic [ict_pkg::SLOT_PORT_W-1:0]     i_slot,
    input  logic                                i_word_sel,
    input  logic [ict_pkg::WORD_W-1:0]          i_frame_word,
    input  logic signed [ict_pkg::CODE_W-1:0]   i_code,
    output logic                                o_valid,
    output logic                                o_led,
    output logic                                o_busy_res,
    output logic                                o_hit,
    output logic [ict_pkg::SLOT_PORT_W-1:0]     o_hit_slot,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import ict_pkg::*;

    t_cfg  r_cfg;
    t_cmd  front_cmd;
    t_cmd  queue_cmd;
    logic  front_push;
    logic  queue_full;
    logic  queue_valid;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period    <= PERIOD_RST;
            r_cfg.on_ticks  <= ON_TICKS_RST;
            r_cfg.bit_ticks <= BIT_TICKS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_PERIOD:    r_cfg.period    <= pwdata[TICK_W-1:0];
                REG_ON_TICKS:  r_cfg.on_ticks  <= pwdata[TICK_W-1:0];
                REG_BIT_TICKS: r_cfg.bit_ticks <= pwdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PERIOD:    prdata = {16'd0, r_cfg.period};
            REG_ON_TICKS:  prdata = {16'd0, r_cfg.on_ticks};
            REG_BIT_TICKS: prdata = {16'd0, r_cfg.bit_ticks};
            default:       prdata = '0;
        endcase
    end

    ict_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .i_start      (start),
        .i_full       (queue_full),
        .i_op         (i_op),
        .i_slot       (i_slot),
        .i_word_sel   (i_word_sel),
        .i_frame_word (i_frame_word),
        .i_code       (i_code),
        .o_busy       (busy),
        .o_push       (front_push),
        .o_cmd        (front_cmd)
    );

    ict_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    ict_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (queue_valid),
        .i_cmd      (queue_cmd),
        .i_cfg      (r_cfg),
        .o_valid    (o_valid),
        .o_led      (o_led),
        .o_busy_res (o_busy_res),
        .o_hit      (o_hit),
        .o_hit_slot (o_hit_slot)
    );

endmodule

`default_nettype wire
